/* sv/base64_encoder_line_wrap_top_defines.svh */
// assertion macros for the base64 encoder with line wrapping
// used by b64lw_queue; expects clk and rst_n in scope
`ifndef BASE64_ENCODER_LINE_WRAP_TOP_DEFINES_SVH
`define BASE64_ENCODER_LINE_WRAP_TOP_DEFINES_SVH

`ifndef SYNTH
`define B64LW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define B64LW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define B64LW_ASSERT_IMP(label, ante, cons, msg)
`define B64LW_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

/* sv/b64lw_pkg.sv */
// shared types, constants and the alphabet function of the base64 encoder
// no dependencies; used by every module of the block
package b64lw_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_NEWLINE_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUPS_PER_LINE = 1'b1;

    localparam logic [1:0] NL_NONE = 2'd0;
    localparam logic [1:0] NL_LF   = 2'd1;
    localparam logic [1:0] NL_CRLF = 2'd2;

    localparam logic [7:0] GPL_RESET = 8'd16;

    localparam logic [7:0] CHAR_PAD = 8'h3d;
    localparam logic [7:0] CHAR_LF  = 8'h0a;
    localparam logic [7:0] CHAR_CR  = 8'h0d;

    typedef enum logic [1:0] {
        BRK_NONE = 2'd0,
        BRK_LF   = 2'd1,
        BRK_CRLF = 2'd2
    } brk_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_item_t;

    // one classified group waiting to be serialised
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        brk_t        brk;
        logic        final_group;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)
            r = {2'b00, v} + 8'd65;
        else if (v < 6'd52)
            r = {2'b00, v} + 8'd71;
        else if (v < 6'd62)
            r = {2'b00, v} - 8'd4;
        else if (v == 6'd62)
            r = 8'h2b;
        else
            r = 8'h2f;
        return r;
    endfunction

endpackage

/* sv/base64_encoder_line_wrap_top.sv */
// top level of the base64 encoder with line wrapping
// depends on b64lw_pkg, b64lw_front, b64lw_queue and b64lw_back
//
//  channel | direction | handshake            | beat payload
//  --------+-----------+----------------------+---------------------------
//  in      | in        | in_valid / in_stall  | data_byte, final_byte
//  out     | out       | out_valid / out_stall| out_char, last_char
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// one byte beat is taken per cycle while the job queue has room
// the serialiser sends one character per cycle while a job is queued and
//   out is not stalled; a group gives four characters, plus one or two
//   for a line break
// a finished group is queued, then its characters pass the output register
// reset clears counters, phase, queue and config; no clearing pass
// a stall on out holds the output register and backs up into the queue
module base64_encoder_line_wrap_top #(
    parameter int QUEUE_DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  b64lw_pkg::in_item_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output b64lw_pkg::out_item_t                out_data,
    input  logic                                cfg_we,
    input  logic [b64lw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [b64lw_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // job handoff between front end and serialiser
    logic                 push;
    logic                 pop;
    b64lw_pkg::job_t      push_job;
    b64lw_pkg::job_t      head_job;
    b64lw_pkg::q_status_t q_status;

    // collects bytes, counts groups on the line, decides breaks
    b64lw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    // decouples byte intake from character output
    b64lw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // walks each job character by character into the output register
    b64lw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* sv/b64lw_front.sv */
// front end: config registers, byte collection and line counting
// depends on b64lw_pkg; pushes one job per finished group
module b64lw_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  b64lw_pkg::in_item_t                 in_data,
    input  logic                                cfg_we,
    input  logic [b64lw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [b64lw_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  b64lw_pkg::q_status_t                q_status,
    output logic                                push,
    output b64lw_pkg::job_t                     push_job
);

    logic [1:0]  mode_reg;
    logic [7:0]  gpl_reg;
    logic [15:0] pend_reg, pend_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  groups_reg, groups_next;

    logic        accept;
    logic        emit;
    logic        line_full;
    logic [7:0]  groups_inc;
    b64lw_pkg::brk_t line_brk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= b64lw_pkg::NL_NONE;
            gpl_reg  <= b64lw_pkg::GPL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                b64lw_pkg::REG_NEWLINE_MODE:    mode_reg <= cfg_data[1:0];
                b64lw_pkg::REG_GROUPS_PER_LINE: gpl_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign in_stall   = q_status.full;
    assign accept     = in_valid && !q_status.full;
    assign emit       = in_data.final_byte || (phase_reg == 2'd2);
    assign groups_inc = groups_reg + 8'd1;
    assign line_full  = (groups_inc == gpl_reg);

    // mode 3 behaves as no breaks
    always_comb
    begin
        if (mode_reg == b64lw_pkg::NL_CRLF)
            line_brk = b64lw_pkg::BRK_CRLF;
        else if (mode_reg == b64lw_pkg::NL_LF)
            line_brk = b64lw_pkg::BRK_LF;
        else
            line_brk = b64lw_pkg::BRK_NONE;
    end

    always_comb
    begin
        push_job.nbytes      = phase_reg + 2'd1;
        push_job.final_group = in_data.final_byte;
        case (phase_reg)
            2'd0:    push_job.word = {in_data.data_byte, 16'h0000};
            2'd1:    push_job.word = {pend_reg[15:8], in_data.data_byte, 8'h00};
            default: push_job.word = {pend_reg, in_data.data_byte};
        endcase
        // a line break and a closing break never both happen
        if (line_full)
            push_job.brk = line_brk;
        else if (in_data.final_byte && groups_inc != 8'd0)
            push_job.brk = line_brk;
        else
            push_job.brk = b64lw_pkg::BRK_NONE;
    end

    assign push = accept && emit;

    always_comb
    begin
        pend_next   = pend_reg;
        phase_next  = phase_reg;
        groups_next = groups_reg;
        if (accept)
        begin
            if (emit)
            begin
                pend_next  = 16'h0000;
                phase_next = 2'd0;
                if (in_data.final_byte || line_full)
                    groups_next = 8'd0;
                else
                    groups_next = groups_inc;
            end
            else
            begin
                if (phase_reg == 2'd0)
                    pend_next = {in_data.data_byte, 8'h00};
                else
                    pend_next = {pend_reg[15:8], in_data.data_byte};
                phase_next = phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= 16'h0000;
            phase_reg  <= 2'd0;
            groups_reg <= 8'd0;
        end
        else
        begin
            pend_reg   <= pend_next;
            phase_reg  <= phase_next;
            groups_reg <= groups_next;
        end
    end

endmodule

/* sv/b64lw_queue.sv */
// short job queue between the front end and the serialiser
// depends on b64lw_pkg and the assertion macro header
`include "base64_encoder_line_wrap_top_defines.svh"

module b64lw_queue #(
    parameter int DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  b64lw_pkg::job_t        push_job,
    input  logic                   pop,
    output b64lw_pkg::job_t        head_job,
    output b64lw_pkg::q_status_t   status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64lw_pkg::job_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `B64LW_ASSERT_IMP(a_no_push_when_full, push, !status.full, "job pushed into a full queue")
    `B64LW_ASSERT_IMP(a_no_pop_when_empty, pop, !status.empty, "job popped from an empty queue")
    `B64LW_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= FULL_CNT, "queue count beyond depth")
    `B64LW_ASSERT_NXT(a_push_fills, push && !pop && status.empty, !status.empty,
                      "queue still empty after a push")

endmodule

/* sv/b64lw_back.sv */
// back end: queued jobs to characters, one per cycle unless stalled
// depends on b64lw_pkg; output register parts it from the consumer
module b64lw_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  b64lw_pkg::job_t        head_job,
    input  b64lw_pkg::q_status_t   q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output b64lw_pkg::out_item_t   out_data
);

    logic [2:0] idx_reg, idx_next;
    logic [2:0] last_idx;
    logic       load;
    logic [7:0] cur_char;
    logic       out_valid_reg, out_valid_next;
    b64lw_pkg::out_item_t out_reg;

    always_comb
    begin
        case (head_job.brk)
            b64lw_pkg::BRK_CRLF: last_idx = 3'd5;
            b64lw_pkg::BRK_LF:   last_idx = 3'd4;
            default:             last_idx = 3'd3;
        endcase
    end

    always_comb
    begin
        case (idx_reg)
            3'd0: cur_char = b64lw_pkg::b64_char(head_job.word[23:18]);
            3'd1: cur_char = b64lw_pkg::b64_char(head_job.word[17:12]);
            3'd2: cur_char = (head_job.nbytes >= 2'd2) ?
                             b64lw_pkg::b64_char(head_job.word[11:6]) : b64lw_pkg::CHAR_PAD;
            3'd3: cur_char = (head_job.nbytes == 2'd3) ?
                             b64lw_pkg::b64_char(head_job.word[5:0]) : b64lw_pkg::CHAR_PAD;
            3'd4: cur_char = (head_job.brk == b64lw_pkg::BRK_CRLF) ?
                             b64lw_pkg::CHAR_CR : b64lw_pkg::CHAR_LF;
            default: cur_char = b64lw_pkg::CHAR_LF;
        endcase
    end

    assign load = !q_status.empty && (!out_valid_reg || !out_stall);
    assign pop  = load && (idx_reg == last_idx);

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = (idx_reg == last_idx) ? 3'd0 : idx_reg + 3'd1;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.out_char  <= cur_char;
            out_reg.last_char <= head_job.final_group && (idx_reg == last_idx);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* sim/tb.sv */
// self-checking bench for base64_encoder_line_wrap_top: directed, random and back-pressure runs
// depends on b64lw_pkg for the beat structs, register indexes and newline codes
// carries its own encoder prediction and checks each output beat against it
module tb;

    // code 3 of the newline register has no meaning of its own and must act as no breaks
    localparam logic [1:0] NL_UNUSED = 2'd3;
    // cycles allowed after the last expected character before touching the registers
    localparam int SETTLE_CYCLES = 8;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    b64lw_pkg::in_item_t              in_data;
    logic                             out_valid;
    logic                             out_stall;
    b64lw_pkg::out_item_t             out_data;
    logic                             cfg_we;
    logic [b64lw_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [b64lw_pkg::CFG_DATA_W-1:0] cfg_data;

    // prediction state: register copies and the encoder's own working state
    logic [1:0]  nl_mode;
    logic [7:0]  line_gpl;
    logic [15:0] pend_bytes;
    logic [1:0]  pend_cnt;
    logic [7:0]  line_groups;
    string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // characters still owed by the block, oldest first
    b64lw_pkg::out_item_t encoded_chars[$];

    // idling controls shared between the stimulus and the stall process
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_left;

    int          n_mismatch;
    int          n_bytes;
    int          n_chars;
    int          n_writes;
    int          n_messages;

    base64_encoder_line_wrap_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // encoder prediction
    // ------------------------------------------------------------------

    function automatic void push_char(input logic [7:0] ch);
        b64lw_pkg::out_item_t beat;
        beat.out_char  = ch;
        beat.last_char = 1'b0;
        encoded_chars.push_back(beat);
    endfunction

    function automatic void push_line_break();
        if (nl_mode == b64lw_pkg::NL_CRLF)
            push_char(b64lw_pkg::CHAR_CR);
        push_char(b64lw_pkg::CHAR_LF);
    endfunction

    // consumes one accepted byte beat and queues the characters it produces
    function automatic void encode_byte(input logic [7:0] raw, input logic fin);
        logic [23:0]          word;
        int                   nbytes;
        logic                 breaks_on;
        b64lw_pkg::out_item_t tail;
        breaks_on = (nl_mode == b64lw_pkg::NL_LF) || (nl_mode == b64lw_pkg::NL_CRLF);
        // bytes one and two of a group only get stored unless the message ends there
        if (pend_cnt < 2 && !fin)
        begin
            if (pend_cnt == 0)
                pend_bytes = {raw, 8'h00};
            else
                pend_bytes[7:0] = raw;
            pend_cnt = pend_cnt + 2'd1;
            return;
        end
        // left-align the group in 24 bits
        case (pend_cnt)
            2'd0:
            begin
                word   = {raw, 16'h0000};
                nbytes = 1;
            end
            2'd1:
            begin
                word   = {pend_bytes[15:8], raw, 8'h00};
                nbytes = 2;
            end
            default:
            begin
                word   = {pend_bytes, raw};
                nbytes = 3;
            end
        endcase
        push_char(alphabet[word[23:18]]);
        push_char(alphabet[word[17:12]]);
        push_char(nbytes >= 2 ? alphabet[word[11:6]] : b64lw_pkg::CHAR_PAD);
        push_char(nbytes == 3 ? alphabet[word[5:0]] : b64lw_pkg::CHAR_PAD);
        // group count wraps at 256, so a zero line length means 256 groups
        line_groups = line_groups + 8'd1;
        if (line_groups == line_gpl)
        begin
            line_groups = 8'd0;
            if (breaks_on)
                push_line_break();
        end
        if (fin)
        begin
            // a partial last line still gets closed
            if (breaks_on && line_groups != 8'd0)
                push_line_break();
            tail = encoded_chars.pop_back();
            tail.last_char = 1'b1;
            encoded_chars.push_back(tail);
            line_groups = 8'd0;
        end
        pend_bytes = 16'h0000;
        pend_cnt   = 2'd0;
    endfunction

    // ------------------------------------------------------------------
    // output side: stall driver and character checker
    // ------------------------------------------------------------------

    // a hold-off count overrides the random stall so the block can back up
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        $display("mismatch at %0t: %s, got %h expected %h", $realtime, what, got, want);
        n_mismatch = n_mismatch + 1;
    endtask

    // one output beat per accepting edge, compared field by field
    always @(posedge clk)
    begin : check_chars
        b64lw_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_chars = n_chars + 1;
            if (encoded_chars.size() == 0)
                report_mismatch("character with none expected", out_data, 9'h000);
            else
            begin
                want = encoded_chars.pop_front();
                if (out_data.out_char !== want.out_char)
                    report_mismatch("out_char", out_data, want);
                if (out_data.last_char !== want.last_char)
                    report_mismatch("last_char", out_data, want);
            end
        end
    end

    // ------------------------------------------------------------------
    // input side helpers
    // ------------------------------------------------------------------

    // offers one byte beat after a random gap and returns on the accepting edge;
    // valid is left high so a following beat can go out back to back
    task automatic send_byte(input logic [7:0] raw, input logic fin);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: raw, final_byte: fin};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        encode_byte(raw, fin);
        n_bytes = n_bytes + 1;
        if (fin)
            n_messages = n_messages + 1;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    task automatic send_group(input logic fin);
        send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), fin);
    endtask

    // stops offering beats and waits for every owed character, then lets the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (encoded_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [b64lw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == b64lw_pkg::REG_NEWLINE_MODE)
            nl_mode = val[1:0];
        else
            line_gpl = val;
        n_writes = n_writes + 1;
        @(posedge clk);
    endtask

    // the unused upper bits of the mode write get random values
    task automatic configure(input logic [1:0] mode, input logic [7:0] gpl);
        drain();
        write_reg(b64lw_pkg::REG_NEWLINE_MODE, {6'($urandom_range(63)), mode});
        write_reg(b64lw_pkg::REG_GROUPS_PER_LINE, gpl);
    endtask

    task automatic configure_random();
        logic [7:0] gpl;
        case ($urandom_range(5))
            0:       gpl = 8'd1;
            1:       gpl = 8'd255;
            2:       gpl = 8'd0;
            default: gpl = 8'($urandom_range(2, 5));
        endcase
        configure(2'($urandom_range(3)), gpl);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: no breaks, 16 groups per line; one, two and three byte groups
    task automatic test_group_padding();
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'hfb, 1'b0);
        send_byte(8'hef, 1'b0);
        send_byte(8'hbe, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
    endtask

    // LF and CR LF breaks, closing break on a partial line, and the unused mode code
    task automatic test_line_breaks();
        configure(b64lw_pkg::NL_LF, 8'd1);
        send_message(3);
        send_message(1);
        configure(b64lw_pkg::NL_CRLF, 8'd2);
        send_message(4);
        send_message(1);
        configure(NL_UNUSED, 8'd1);
        send_message(3);
    endtask

    // groups are counted with breaks off, and a register write mid-message applies
    // from the next beat on
    task automatic test_count_without_breaks();
        configure(b64lw_pkg::NL_NONE, 8'd2);
        send_group(1'b0);
        configure(b64lw_pkg::NL_LF, 8'd2);
        send_group(1'b1);
    endtask

    // a zero line length gives no break inside a short message; lowering the
    // length mid-line lets the count run on past the new length
    task automatic test_long_lines();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(b64lw_pkg::NL_LF, 8'd0);
        for (int g = 0; g < 8; g++)
            send_group(g == 7);
        configure(b64lw_pkg::NL_LF, 8'd6);
        for (int g = 0; g < 5; g++)
            send_group(1'b0);
        configure(b64lw_pkg::NL_CRLF, 8'd2);
        for (int g = 0; g < 4; g++)
            send_group(g == 3);
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_target);
        int sent;
        int len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        configure_random();
        while (sent < n_target)
        begin
            if ($urandom_range(3) == 0)
                configure_random();
            len = ($urandom_range(7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
            send_message(len);
            sent = sent + len;
        end
    endtask

    // receiver holds off while the sender keeps offering beats, so the queue fills
    // and the input stalls; then the sender waits for a full drain before resuming
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(b64lw_pkg::NL_CRLF, 8'd1);
        hold_left = 400;
        send_message(24);
        drain();
        send_message(7);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        nl_mode     = b64lw_pkg::NL_NONE;
        line_gpl    = b64lw_pkg::GPL_RESET;
        pend_bytes  = 16'h0000;
        pend_cnt    = 2'd0;
        line_groups = 8'd0;
        tx_idle_pct = 17;
        rx_idle_pct = 72;
        hold_left   = 0;
        n_mismatch  = 0;
        n_bytes     = 0;
        n_chars     = 0;
        n_writes    = 0;
        n_messages  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_group_padding();
        test_line_breaks();
        test_count_without_breaks();
        test_random_phase(17, 72, 25);
        test_random_phase(72, 17, 25);
        test_random_phase(0, 0, 25);
        test_long_lines();
        test_backpressure();
        drain();

        if (encoded_chars.size() != 0)
            report_mismatch("characters never sent", 9'h000, encoded_chars[0]);
        $display("encoded %0d messages, %0d byte beats in, %0d characters out, %0d writes",
                 n_messages, n_bytes, n_chars, n_writes);
        $display("covered padding, LF and CR LF wrapping, zero and lowered line lengths");
        $display("and a full back-up of the queue under a long receiver hold-off");
        if (n_mismatch == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
